/* rtl/core/bmdc_pkg.sv */
// Package for the button motor duty controller.
// Holds the state, configuration and result types, register indexes and reset values.
// No dependencies.
package bmdc_pkg;

   localparam int DUTY_W  = 7;
   localparam int IDLE_W  = 8;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 8;

   localparam logic [CSR_IDX_W-1:0] REG_STEP_SIZE  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_MAX_DUTY   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_IDLE_LIMIT = 2'd2;

   localparam logic [DUTY_W-1:0] STEP_SIZE_RESET  = 7'd10;
   localparam logic [DUTY_W-1:0] MAX_DUTY_RESET   = 7'd100;
   localparam logic [IDLE_W-1:0] IDLE_LIMIT_RESET = 8'd70;
   localparam logic [IDLE_W-1:0] IDLE_SAT         = 8'd255;

   typedef enum logic [1:0] {
      WAIT_NONE = 2'd0,
      WAIT_IDLE = 2'd1,
      WAIT_HOLD = 2'd2
   } wait_type;

   typedef struct packed {
      logic [DUTY_W-1:0] step_size;
      logic [DUTY_W-1:0] max_duty;
      logic [IDLE_W-1:0] idle_limit;
   } cfg_type;

   typedef struct packed {
      logic [DUTY_W-1:0] duty_level;
      logic              right_locked;
      logic              left_locked;
      logic [IDLE_W-1:0] idle_polls;
      logic              right_active;
   } state_type;

   typedef struct packed {
      logic [DUTY_W-1:0] right_duty;
      logic [DUTY_W-1:0] left_duty;
      logic              moved;
      logic              stopped;
      wait_type          wait_code;
   } result_type;

endpackage

/* rtl/core/button_motor_duty_controller_unit.sv */
// Top level of the button motor duty controller: stream ports, registers, state.
// Depends on bmdc_pkg and bmdc_step.
//
// Each request transaction is one poll of four buttons and gives exactly one response
// transaction, registered on acceptance. One poll is accepted per clock unless a full
// response register is held; state loops combinationally through bmdc_step, and the
// response register reloads when empty or drained in the same cycle. The user must
// write configuration registers via the csr_ port with no poll in flight (unenforced).
module button_motor_duty_controller_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // Bits from low: inc_right_n, dec_right, inc_left_n, dec_left, zero fill.
   input  logic [7:0]                          req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // Bits from low: right_duty[6:0], left_duty[6:0], moved, stopped,
   // wait_code[1:0], zero fill.
   output logic [23:0]                         rsp_tdata,
   input  logic                                csr_we,
   input  logic [bmdc_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [bmdc_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import bmdc_pkg::*;

   cfg_type    cfg_ff, cfg_in;
   state_type  state_ff, state_in, state_next;
   result_type result, rsp_data_ff, rsp_data_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       accept;

   bmdc_step u_step (
      .cfg         (cfg_ff),
      .state       (state_ff),
      .inc_right_n (req_tdata[0]),
      .dec_right   (req_tdata[1]),
      .inc_left_n  (req_tdata[2]),
      .dec_left    (req_tdata[3]),
      .state_next  (state_next),
      .result      (result)
   );

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            REG_STEP_SIZE:  cfg_in.step_size  = csr_wdata[DUTY_W-1:0];
            REG_MAX_DUTY:   cfg_in.max_duty   = csr_wdata[DUTY_W-1:0];
            REG_IDLE_LIMIT: cfg_in.idle_limit = csr_wdata[IDLE_W-1:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
      state_in     = accept ? state_next : state_ff;
      rsp_data_in  = accept ? result : rsp_data_ff;
      rsp_valid_in = accept || (rsp_valid_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.step_size  <= STEP_SIZE_RESET;
         cfg_ff.max_duty   <= MAX_DUTY_RESET;
         cfg_ff.idle_limit <= IDLE_LIMIT_RESET;
         state_ff          <= '0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, rsp_data_ff.wait_code, rsp_data_ff.stopped, rsp_data_ff.moved,
                        rsp_data_ff.left_duty, rsp_data_ff.right_duty};

endmodule

/* rtl/core/bmdc_step.sv */
// Next-state and result logic for one button poll.
// Depends on bmdc_pkg.
module bmdc_step (
   input  bmdc_pkg::cfg_type    cfg,
   input  bmdc_pkg::state_type  state,
   input  logic                 inc_right_n,
   input  logic                 dec_right,
   input  logic                 inc_left_n,
   input  logic                 dec_left,
   output bmdc_pkg::state_type  state_next,
   output bmdc_pkg::result_type result
);
   import bmdc_pkg::*;

   logic              p_inc_r, p_dec_r, p_inc_l, p_dec_l;
   logic [2:0]        press_count;
   logic              is_inc, is_right, blocked, ok;
   logic [DUTY_W:0]   sum;
   logic [DUTY_W-1:0] inc_duty, dec_duty;
   logic [IDLE_W-1:0] idle_inc;

   always_comb begin
      p_inc_r = ~inc_right_n;
      p_dec_r = dec_right;
      p_inc_l = ~inc_left_n;
      p_dec_l = dec_left;
      press_count = {2'b00, p_inc_r} + {2'b00, p_dec_r} + {2'b00, p_inc_l} + {2'b00, p_dec_l};

      is_right = p_inc_r | p_dec_r;
      is_inc   = p_inc_r | p_inc_l;
      blocked  = is_right ? state.left_locked : state.right_locked;

      sum      = {1'b0, state.duty_level} + {1'b0, cfg.step_size};
      inc_duty = (sum > {1'b0, cfg.max_duty}) ? cfg.max_duty : sum[DUTY_W-1:0];
      dec_duty = (state.duty_level > cfg.step_size) ?
                 (state.duty_level - cfg.step_size) : '0;

      if (is_inc) begin
         ok = !blocked && (state.duty_level < cfg.max_duty);
      end else begin
         ok = !blocked && (state.duty_level != '0);
      end

      idle_inc = (state.idle_polls < IDLE_SAT) ? state.idle_polls + 8'd1 : state.idle_polls;

      state_next = state;
      result.moved     = 1'b0;
      result.stopped   = 1'b0;
      result.wait_code = WAIT_NONE;

      if (press_count != 3'd0) begin
         state_next.idle_polls = '0;
         if (press_count == 3'd1 && ok) begin
            state_next.duty_level = is_inc ? inc_duty : dec_duty;
            if (is_right) begin
               state_next.right_locked = 1'b1;
               state_next.right_active = 1'b1;
            end else begin
               state_next.left_locked  = 1'b1;
               state_next.right_active = 1'b0;
            end
            result.moved     = 1'b1;
            result.wait_code = WAIT_HOLD;
         end
      end else begin
         result.wait_code = WAIT_IDLE;
         state_next.idle_polls = idle_inc;
         if (idle_inc >= cfg.idle_limit) begin
            state_next = '0;
            result.stopped = 1'b1;
         end
      end

      result.right_duty = state_next.right_active ? state_next.duty_level : '0;
      result.left_duty  = state_next.right_active ? '0 : state_next.duty_level;
   end

endmodule
